/* sv/sdpg_pkg.sv */
// types and constants shared by the step pulse generator modules
`timescale 1ns / 1ps

package sdpg_pkg;

    localparam int unsigned PERIOD_W = 20;
    localparam int unsigned HIGH_W   = 8;
    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned PEND_W   = 32;
    localparam int unsigned STEPS_W  = 31;
    localparam int unsigned CFG_W    = 20;

    localparam logic [1:0] ACT_TICK       = 2'd0;
    localparam logic [1:0] ACT_ADD_FIRST  = 2'd1;
    localparam logic [1:0] ACT_ADD_SECOND = 2'd2;

    localparam logic CFG_PERIOD     = 1'b0;
    localparam logic CFG_PULSE_HIGH = 1'b1;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd1000;
    localparam logic [HIGH_W-1:0]   HIGH_RESET   = 8'd3;

    typedef enum logic [1:0] {
        AXIS_NONE   = 2'd0,
        AXIS_FIRST  = 2'd1,
        AXIS_SECOND = 2'd2
    } t_axis;

    typedef struct packed {
        logic [PERIOD_W-1:0] period_ticks;
        logic [HIGH_W-1:0]   pulse_high_ticks;
    } t_cfg;

    typedef struct packed {
        logic step_first;
        logic dir_first;
        logic step_second;
        logic dir_second;
        logic idle;
    } t_lines;

endpackage

/* sv/sdpg_cfg.sv */
// configuration registers for period and pulse high time
`timescale 1ns / 1ps

module sdpg_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [sdpg_pkg::CFG_W-1:0] i_cfg_data,
    output sdpg_pkg::t_cfg             o_cfg
);
    import sdpg_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period_ticks     <= PERIOD_RESET;
            r_cfg.pulse_high_ticks <= HIGH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PERIOD:     r_cfg.period_ticks     <= i_cfg_data[PERIOD_W-1:0];
                CFG_PULSE_HIGH: r_cfg.pulse_high_ticks <= i_cfg_data[HIGH_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* sv/sdpg_engine.sv */
// pending counts, round-robin move start and pulse timing for both axes
`timescale 1ns / 1ps

module sdpg_engine (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic [1:0]                          i_action,
    input  logic signed [sdpg_pkg::COUNT_W-1:0] i_step_count,
    input  sdpg_pkg::t_cfg                      i_cfg,
    output sdpg_pkg::t_lines                    o_lines
);
    import sdpg_pkg::*;

    logic signed [PEND_W-1:0] r_pend_first, n_pend_first;
    logic signed [PEND_W-1:0] r_pend_second, n_pend_second;
    logic [STEPS_W-1:0]       r_steps_left, n_steps_left;
    logic [PERIOD_W-1:0]      r_phase, n_phase;
    t_axis                    r_active, n_active;
    logic                     r_serve_second, n_serve_second;
    logic                     r_dir_first, n_dir_first;
    logic                     r_dir_second, n_dir_second;

    function automatic logic signed [PEND_W-1:0] sat_add(
        input logic signed [PEND_W-1:0]  a,
        input logic signed [COUNT_W-1:0] b
    );
        logic [PEND_W:0] s;
        s = {a[PEND_W-1], a} + {{(PEND_W-COUNT_W+1){b[COUNT_W-1]}}, b};
        if (s[PEND_W] != s[PEND_W-1]) begin
            sat_add = s[PEND_W] ? {1'b1, {(PEND_W-1){1'b0}}} : {1'b0, {(PEND_W-1){1'b1}}};
        end else begin
            sat_add = s[PEND_W-1:0];
        end
    endfunction

    // next state
    always_comb begin
        logic [PERIOD_W-1:0]      v_high;
        logic [PERIOD_W-1:0]      v_eff;
        logic [PERIOD_W-1:0]      v_phase_inc;
        logic                     v_take_first;
        logic                     v_take_second;
        logic signed [PEND_W-1:0] v_take;
        logic [PEND_W-1:0]        v_mag;

        n_pend_first   = r_pend_first;
        n_pend_second  = r_pend_second;
        n_steps_left   = r_steps_left;
        n_phase        = r_phase;
        n_active       = r_active;
        n_serve_second = r_serve_second;
        n_dir_first    = r_dir_first;
        n_dir_second   = r_dir_second;

        v_high      = {{(PERIOD_W-HIGH_W){1'b0}}, i_cfg.pulse_high_ticks};
        v_eff       = (i_cfg.period_ticks <= v_high) ? v_high + 1'b1 : i_cfg.period_ticks;
        v_phase_inc = r_phase + 1'b1;

        if (r_serve_second) begin
            v_take_second = (r_pend_second != '0);
            v_take_first  = (r_pend_second == '0) && (r_pend_first != '0);
        end else begin
            v_take_first  = (r_pend_first != '0);
            v_take_second = (r_pend_first == '0) && (r_pend_second != '0);
        end
        v_take = v_take_second ? r_pend_second : r_pend_first;
        v_mag  = v_take[PEND_W-1] ? -v_take : v_take;

        if (i_en) begin
            case (i_action)
                ACT_TICK: begin
                    if (r_active != AXIS_NONE) begin
                        if (v_phase_inc >= v_eff) begin
                            n_phase = '0;
                            if (r_steps_left == '0) begin
                                n_active = AXIS_NONE;
                            end else begin
                                n_steps_left = r_steps_left - 1'b1;
                            end
                        end else begin
                            n_phase = v_phase_inc;
                        end
                    end
                    if (n_active == AXIS_NONE) begin
                        n_phase = '0;
                        if (v_take_first || v_take_second) begin
                            n_steps_left   = STEPS_W'(v_mag - 1'b1);
                            n_active       = v_take_second ? AXIS_SECOND : AXIS_FIRST;
                            n_serve_second = v_take_first;
                            if (v_take_second) begin
                                n_pend_second = '0;
                                n_dir_second  = !v_take[PEND_W-1];
                            end else begin
                                n_pend_first = '0;
                                n_dir_first  = !v_take[PEND_W-1];
                            end
                        end
                    end
                end
                ACT_ADD_FIRST:  n_pend_first  = sat_add(r_pend_first, i_step_count);
                ACT_ADD_SECOND: n_pend_second = sat_add(r_pend_second, i_step_count);
                default: ;
            endcase
        end
    end

    // line levels after this transfer
    always_comb begin
        logic v_line_high;
        v_line_high = (n_active != AXIS_NONE) &&
                      (n_phase < {{(PERIOD_W-HIGH_W){1'b0}}, i_cfg.pulse_high_ticks});
        o_lines.step_first  = (n_active == AXIS_FIRST) && v_line_high;
        o_lines.dir_first   = n_dir_first;
        o_lines.step_second = (n_active == AXIS_SECOND) && v_line_high;
        o_lines.dir_second  = n_dir_second;
        o_lines.idle        = (n_active == AXIS_NONE) && (n_pend_first == '0) &&
                              (n_pend_second == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_first   <= '0;
            r_pend_second  <= '0;
            r_steps_left   <= '0;
            r_phase        <= '0;
            r_active       <= AXIS_NONE;
            r_serve_second <= 1'b0;
            r_dir_first    <= 1'b0;
            r_dir_second   <= 1'b0;
        end else begin
            r_pend_first   <= n_pend_first;
            r_pend_second  <= n_pend_second;
            r_steps_left   <= n_steps_left;
            r_phase        <= n_phase;
            r_active       <= n_active;
            r_serve_second <= n_serve_second;
            r_dir_first    <= n_dir_first;
            r_dir_second   <= n_dir_second;
        end
    end

    a_idle_phase_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active == AXIS_NONE |-> r_phase == '0)
        else $error("phase counter running with no move");

    a_request_keeps_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && (i_action == ACT_ADD_FIRST || i_action == ACT_ADD_SECOND)
        |=> $stable(r_active) && $stable(r_phase) && $stable(r_steps_left))
        else $error("move request disturbed the running move");

    a_start_clears_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && i_action == ACT_TICK && r_active == AXIS_NONE && r_pend_first != '0
        && !r_serve_second |=> r_active == AXIS_FIRST && r_pend_first == '0)
        else $error("first axis not started from its pending count");

endmodule

/* sv/dual_axis_step_pulse_generator.sv */
// top level of the dual axis step and direction pulse generator
`timescale 1ns / 1ps

// Takes one transfer per clock on the input channel while the output is not stalled, each a
// microsecond tick or a signed step request for one axis, and gives one transfer of step,
// direction and idle levels per input transfer, from an input register and a result register.
// The state update of the step engine keeps up with that rate. Configuration writes
// take effect at once and belong between moves, while idle is high.

module dual_axis_step_pulse_generator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_action,
    input  logic signed [sdpg_pkg::COUNT_W-1:0] i_step_count,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_step_first,
    output logic                                o_dir_first,
    output logic                                o_step_second,
    output logic                                o_dir_second,
    output logic                                o_idle,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [sdpg_pkg::CFG_W-1:0]          i_cfg_data
);
    import sdpg_pkg::*;

    logic                       r_in_valid;
    logic [1:0]                 r_action;
    logic signed [COUNT_W-1:0]  r_step_count;
    logic                       r_out_valid;
    t_lines                     r_lines;
    t_lines                     w_lines;
    t_cfg                       w_cfg;
    logic                       w_advance;
    logic                       w_accept;

    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_accept   = i_in_valid && !o_in_stall;

    sdpg_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    sdpg_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_advance),
        .i_action     (r_action),
        .i_step_count (r_step_count),
        .i_cfg        (w_cfg),
        .o_lines      (w_lines)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_accept || (r_in_valid && !w_advance);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action     <= i_action;
            r_step_count <= i_step_count;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_advance || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_lines <= w_lines;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_step_first  = r_lines.step_first;
    assign o_dir_first   = r_lines.dir_first;
    assign o_step_second = r_lines.step_second;
    assign o_dir_second  = r_lines.dir_second;
    assign o_idle        = r_lines.idle;

    a_one_step_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_step_first && o_step_second))
        else $error("both step lines high");

    a_idle_no_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_idle |-> !o_step_first && !o_step_second)
        else $error("step line high while idle");

endmodule

/* tb/step_pulse_checker.sv */
// checker that predicts the step, direction and idle lines and compares every output transfer
`timescale 1ns / 1ps

module step_pulse_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic [1:0]                          i_action,
    input  logic signed [sdpg_pkg::COUNT_W-1:0] i_step_count,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic                                i_step_first,
    input  logic                                i_dir_first,
    input  logic                                i_step_second,
    input  logic                                i_dir_second,
    input  logic                                i_idle,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [sdpg_pkg::CFG_W-1:0]          i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_waiting,
    output logic                                o_quiet
);
    import sdpg_pkg::*;

    logic signed [PEND_W-1:0] pend_first;
    logic signed [PEND_W-1:0] pend_second;
    logic [STEPS_W-1:0]       steps_to_go;
    logic [PERIOD_W-1:0]      phase;
    t_axis                    moving_axis;
    logic                     second_turn;
    logic                     dir_first_q;
    logic                     dir_second_q;
    t_cfg                     cfg;
    t_lines                   levels_due [$];
    int                       mismatches = 0;

    assign o_fail_count = mismatches;

    task automatic flag_mismatch(input string what);
        $display("%0t ns: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_line(input string name, input logic got, input logic want);
        if (got !== want) begin
            flag_mismatch($sformatf("%s is %b, predicted %b", name, got, want));
        end
    endtask

    function automatic logic signed [PEND_W-1:0] clamp_add(
        input logic signed [PEND_W-1:0]  base,
        input logic signed [COUNT_W-1:0] delta
    );
        logic [PEND_W:0] total;
        total = {base[PEND_W-1], base} + {{(PEND_W+1-COUNT_W){delta[COUNT_W-1]}}, delta};
        if (total[PEND_W:PEND_W-1] == 2'b01) begin
            return {1'b0, {(PEND_W-1){1'b1}}};
        end
        if (total[PEND_W:PEND_W-1] == 2'b10) begin
            return {1'b1, {(PEND_W-1){1'b0}}};
        end
        return total[PEND_W-1:0];
    endfunction

    function automatic bit claim_axis(input t_axis ax);
        logic signed [PEND_W-1:0] held;
        logic [PEND_W-1:0]        size;
        held = (ax == AXIS_FIRST) ? pend_first : pend_second;
        if (held == 0) begin
            return 1'b0;
        end
        size = held[PEND_W-1] ? -held : held;
        if (ax == AXIS_FIRST) begin
            pend_first  = '0;
            dir_first_q = !held[PEND_W-1];
            second_turn = 1'b1;
        end else begin
            pend_second  = '0;
            dir_second_q = !held[PEND_W-1];
            second_turn  = 1'b0;
        end
        steps_to_go = size[STEPS_W-1:0] - 1'b1;
        phase       = '0;
        moving_axis = ax;
        return 1'b1;
    endfunction

    function automatic void advance_tick();
        logic [PERIOD_W:0] span;
        if (moving_axis != AXIS_NONE) begin
            if (cfg.period_ticks <= cfg.pulse_high_ticks) begin
                span = cfg.pulse_high_ticks + 1'b1;
            end else begin
                span = cfg.period_ticks;
            end
            phase = phase + 1'b1;
            if (phase >= span) begin
                phase = '0;
                if (steps_to_go == 0) begin
                    moving_axis = AXIS_NONE;
                end else begin
                    steps_to_go = steps_to_go - 1'b1;
                end
            end
        end
        if (moving_axis == AXIS_NONE) begin
            phase = '0;
            if (second_turn) begin
                if (!claim_axis(AXIS_SECOND)) begin
                    void'(claim_axis(AXIS_FIRST));
                end
            end else begin
                if (!claim_axis(AXIS_FIRST)) begin
                    void'(claim_axis(AXIS_SECOND));
                end
            end
        end
    endfunction

    function automatic t_lines predict_levels(
        input logic [1:0]                act,
        input logic signed [COUNT_W-1:0] cnt
    );
        t_lines lv;
        logic   high_now;
        case (act)
            ACT_TICK:       advance_tick();
            ACT_ADD_FIRST:  pend_first = clamp_add(pend_first, cnt);
            ACT_ADD_SECOND: pend_second = clamp_add(pend_second, cnt);
            default:        ;
        endcase
        high_now       = moving_axis != AXIS_NONE && phase < cfg.pulse_high_ticks;
        lv.step_first  = moving_axis == AXIS_FIRST && high_now;
        lv.dir_first   = dir_first_q;
        lv.step_second = moving_axis == AXIS_SECOND && high_now;
        lv.dir_second  = dir_second_q;
        lv.idle        = moving_axis == AXIS_NONE && pend_first == 0 && pend_second == 0;
        return lv;
    endfunction

    function automatic void restart_model();
        cfg.period_ticks     = PERIOD_RESET;
        cfg.pulse_high_ticks = HIGH_RESET;
        pend_first   = '0;
        pend_second  = '0;
        steps_to_go  = '0;
        phase        = '0;
        moving_axis  = AXIS_NONE;
        second_turn  = 1'b0;
        dir_first_q  = 1'b0;
        dir_second_q = 1'b0;
        levels_due.delete();
    endfunction

    always @(posedge i_clk) begin : watch
        t_lines want;
        if (!i_rst_n) begin
            restart_model();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_PERIOD) begin
                    cfg.period_ticks = i_cfg_data[PERIOD_W-1:0];
                end else begin
                    cfg.pulse_high_ticks = i_cfg_data[HIGH_W-1:0];
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (levels_due.size() == 0) begin
                    flag_mismatch("output transfer with no prediction waiting");
                end else begin
                    want = levels_due.pop_front();
                    check_line("step_first", i_step_first, want.step_first);
                    check_line("dir_first", i_dir_first, want.dir_first);
                    check_line("step_second", i_step_second, want.step_second);
                    check_line("dir_second", i_dir_second, want.dir_second);
                    check_line("idle", i_idle, want.idle);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                levels_due.push_back(predict_levels(i_action, i_step_count));
            end
        end
        o_waiting <= levels_due.size();
        o_quiet   <= moving_axis == AXIS_NONE && pend_first == 0 && pend_second == 0;
    end

endmodule

/* tb/dual_axis_step_pulse_generator_test.sv */
// stimulus and verdict for the dual axis step pulse generator
`timescale 1ns / 1ps

module dual_axis_step_pulse_generator_test;
    import sdpg_pkg::*;

    localparam logic [1:0] ACT_UNUSED   = 2'd3;
    localparam int         DRAIN_CYCLES = 4;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic [1:0]                action;
    logic signed [COUNT_W-1:0] step_count;
    logic                      out_valid;
    logic                      out_stall;
    logic                      step_first;
    logic                      dir_first;
    logic                      step_second;
    logic                      dir_second;
    logic                      idle;
    logic                      cfg_we;
    logic                      cfg_index;
    logic [CFG_W-1:0]          cfg_data;
    int                        fail_count;
    int                        waiting;
    logic                      model_quiet;
    int unsigned               send_calm;
    int unsigned               stall_calm;

    dual_axis_step_pulse_generator i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_action     (action),
        .i_step_count (step_count),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_step_first (step_first),
        .o_dir_first  (dir_first),
        .o_step_second(step_second),
        .o_dir_second (dir_second),
        .o_idle       (idle),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    step_pulse_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_action     (action),
        .i_step_count (step_count),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_step_first (step_first),
        .i_dir_first  (dir_first),
        .i_step_second(step_second),
        .i_dir_second (dir_second),
        .i_idle       (idle),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_waiting    (waiting),
        .o_quiet      (model_quiet)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly short gaps, a few long ones, and now and then a stretch with none
    function automatic int unsigned pick_gap(inout int unsigned calm, input bit sparse);
        int unsigned r;
        if (calm != 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 999);
        if (r < 15) begin
            calm = $urandom_range(20, 120);
            return 0;
        end
        if (sparse) begin
            return (r < 980) ? 0 : $urandom_range(1, 40);
        end
        if (r < 600) begin
            return 0;
        end
        if (r < 900) begin
            return $urandom_range(1, 3);
        end
        if (r < 980) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 80);
    endfunction

    task automatic send(
        input logic [1:0]                act,
        input logic signed [COUNT_W-1:0] cnt,
        input bit                        sparse
    );
        int unsigned gap;
        gap = pick_gap(send_calm, sparse);
        @(negedge clk);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        step_count <= cnt;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // stop sending and wait until every predicted transfer has come out
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (waiting != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // tick until the engine has no move and nothing pending, then let the outputs drain
    task automatic settle();
        do begin
            send(ACT_TICK, COUNT_W'($urandom), 1'b0);
        end while (!model_quiet);
        drain();
    endtask

    task automatic stir(input int unsigned n, input int unsigned mag, input int unsigned req_pct);
        int unsigned               k;
        int unsigned               pick;
        int                        delta;
        logic [1:0]                axis_act;
        logic signed [COUNT_W-1:0] cnt;
        for (k = 0; k < n; k++) begin
            pick     = $urandom_range(0, 99);
            axis_act = ($urandom_range(0, 1) == 0) ? ACT_ADD_FIRST : ACT_ADD_SECOND;
            cnt      = COUNT_W'($urandom);
            if (pick < 3) begin
                send(ACT_UNUSED, cnt, 1'b0);
            end else if (pick < 7) begin
                // request of random size cancelled before the next tick
                if (cnt == 16'sh8000) begin
                    cnt = 16'sh7FFF;
                end
                send(axis_act, cnt, 1'b0);
                send(axis_act, -cnt, 1'b0);
            end else if (pick < 7 + req_pct) begin
                delta = int'($urandom_range(0, 2 * mag)) - int'(mag);
                send(axis_act, COUNT_W'(delta), 1'b0);
            end else begin
                send(ACT_TICK, cnt, 1'b0);
            end
        end
    endtask

    task automatic run_phase(
        input logic [PERIOD_W-1:0] period,
        input logic [HIGH_W-1:0]   high,
        input int unsigned         n,
        input int unsigned         mag,
        input int unsigned         req_pct
    );
        logic [CFG_W-1:0] high_word;
        high_word                = $urandom;
        high_word[HIGH_W-1:0]    = high;
        write_reg(CFG_PERIOD, CFG_W'(period));
        write_reg(CFG_PULSE_HIGH, high_word);
        stir(n, mag, req_pct);
        settle();
    endtask

    initial begin : out_stall_driver
        int unsigned run;
        int unsigned hold;
        out_stall  = 1'b0;
        stall_calm = 0;
        forever begin
            run  = $urandom_range(1, 20);
            hold = pick_gap(stall_calm, 1'b0);
            @(negedge clk);
            out_stall <= 1'b0;
            repeat (run) @(negedge clk);
            if (hold != 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
        end
    end

    initial begin : stimulus
        int guard;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        action     = ACT_TICK;
        step_count = '0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_PERIOD;
        cfg_data   = '0;
        send_calm  = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset timing, count extremes, unused action, round robin from the first axis
        send(ACT_TICK, 16'sh0000, 1'b0);
        send(ACT_UNUSED, 16'sh7FFF, 1'b0);
        send(ACT_ADD_FIRST, 16'sh7FFF, 1'b0);
        send(ACT_ADD_FIRST, 16'sh8000, 1'b0);
        send(ACT_ADD_FIRST, 16'sh0001, 1'b0);
        send(ACT_ADD_SECOND, 16'shFFFF, 1'b0);
        send(ACT_ADD_FIRST, 16'sh0002, 1'b0);
        send(ACT_TICK, 16'shFFFF, 1'b0);
        send(ACT_UNUSED, 16'sh8000, 1'b0);
        send(ACT_ADD_SECOND, 16'sh0000, 1'b0);
        send(ACT_TICK, 16'sh0000, 1'b0);

        // see the reset high time end, then shorten the period for the rest of the move
        repeat (6) send(ACT_TICK, 16'sh0000, 1'b0);
        drain();
        write_reg(CFG_PERIOD, CFG_W'(5));
        settle();

        run_phase(20'd0, 8'd0, 40, 3, 25);
        run_phase(20'd1, 8'd1, 40, 3, 25);
        run_phase(20'd4, 8'd2, 40, 2, 25);
        run_phase(20'd0, 8'd3, 40, 2, 25);
        run_phase(20'd2, 8'd5, 40, 2, 20);
        run_phase(20'd10, 8'd1, 40, 2, 20);
        run_phase(20'd3, 8'd1, 40, 3, 30);
        run_phase(PERIOD_W'($urandom_range(0, 10)), HIGH_W'($urandom_range(0, 5)), 40, 2, 25);
        run_phase(PERIOD_W'($urandom_range(0, 10)), HIGH_W'($urandom_range(0, 5)), 40, 2, 25);

        // longest high time, with the period raised past the top of the high time field
        write_reg(CFG_PERIOD, CFG_W'(0));
        write_reg(CFG_PULSE_HIGH, CFG_W'(255));
        send(ACT_ADD_FIRST, 16'sh0001, 1'b0);
        settle();

        // widest settings, then a long period with a move under way
        write_reg(CFG_PERIOD, {CFG_W{1'b1}});
        write_reg(CFG_PULSE_HIGH, {CFG_W{1'b1}});
        settle();
        write_reg(CFG_PERIOD, CFG_W'(1000000));
        send(ACT_ADD_SECOND, 16'shFFFD, 1'b0);
        stir(100, 4, 5);

        @(negedge clk);
        in_valid <= 1'b0;
        guard = 0;
        while (waiting != 0 && guard < 50000) begin
            @(negedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && waiting == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
